>>> rtl/pmds_pkg.sv
`timescale 1ns / 1ps

package pmds_pkg;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned BitsPerStageDefault = 4;

  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } op_t;
endpackage

>>> rtl/pmds_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: BITS quotient bits per stage, one stage per register.
// A side word of SIDE_W bits travels alongside each beat.
module pmds_divider #(
  parameter int unsigned W      = pmds_pkg::DataWidthDefault,
  parameter int unsigned BITS   = pmds_pkg::BitsPerStageDefault,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [W-1:0]      in_num,
  input  logic [W-1:0]      in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_quo,
  output logic [W-1:0]      out_rem,
  output logic [W-1:0]      out_den,
  output logic [SIDE_W-1:0] out_side
);
  localparam int unsigned NSTAGE = (W + BITS - 1) / BITS;

  logic [NSTAGE:0]             vld;
  logic [W-1:0]                num [NSTAGE+1];
  logic [W-1:0]                rem [NSTAGE+1];
  logic [W-1:0]                den [NSTAGE+1];
  logic [SIDE_W-1:0]           side [NSTAGE+1];

  assign vld[0]  = in_valid;
  assign num[0]  = in_num;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    logic [W-1:0] num_next;
    logic [W-1:0] rem_next;

    always_comb begin
      logic [W:0] trial;
      logic [W:0] r;
      logic [W-1:0] n;
      r = {1'b0, rem[s]};
      n = num[s];
      trial = '0;
      for (int b = 0; b < BITS; b++) begin
        if ((s * BITS + b) < W) begin
          r = {r[W-1:0], n[W-1]};
          n = {n[W-2:0], 1'b0};
          trial = r - {1'b0, den[s]};
          if (!trial[W]) begin
            r = trial;
            n[0] = 1'b1;
          end
        end
      end
      num_next = n;
      rem_next = r[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
      if (advance) begin
        num[s+1]  <= num_next;
        rem[s+1]  <= rem_next;
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  // quotient bits shift in at the bottom of num; after W bits num holds the quotient
  assign out_valid = vld[NSTAGE];
  assign out_quo   = num[NSTAGE];
  assign out_rem   = rem[NSTAGE];
  assign out_den   = den[NSTAGE];
  assign out_side  = side[NSTAGE];
endmodule

>>> rtl/proportional_mul_div_scaler.sv
`timescale 1ns / 1ps

// Proportional multiply-divide scaler: result = value * numerator / denominator
// computed as (v/d)*n + ((v%d)*n)/d, every product and sum wrapping at DATA_WIDTH.
// Input channel: in_valid/in_ready with operation, value_word, numerator_word,
// denominator_word. Output channel: out_valid/out_ready with result_word and
// divide_by_zero. Signed mode works on magnitudes and negates on odd sign count.
// Each beat passes the magnitude stage, the first pipelined restoring divider,
// the multiply stage, the second divider, the sum stage and the output register.
// Throughput: one beat per cycle while the receiver is not stalling.
// The whole pipeline advances as one when the output register is empty or taken;
// a stalled receiver holds every stage, so in_ready drops and nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
// A zero denominator yields result 0 with divide_by_zero set.
module proportional_mul_div_scaler #(
  parameter int unsigned DATA_WIDTH     = pmds_pkg::DataWidthDefault,
  parameter int unsigned BITS_PER_STAGE = pmds_pkg::BitsPerStageDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pmds_pkg::op_t         operation,
  input  logic [DATA_WIDTH-1:0] value_word,
  input  logic [DATA_WIDTH-1:0] numerator_word,
  input  logic [DATA_WIDTH-1:0] denominator_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] result_word,
  output logic                  divide_by_zero
);
  import pmds_pkg::*;
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned SIDE = W + 2;

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // stage 1: magnitudes
  logic         s1_vld;
  logic [W-1:0] s1_v, s1_n, s1_d;
  logic         s1_neg, s1_zero;
  logic         sv, sn, sd;
  assign sv = (operation == OP_SIGNED) && value_word[W-1];
  assign sn = (operation == OP_SIGNED) && numerator_word[W-1];
  assign sd = (operation == OP_SIGNED) && denominator_word[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid;
    end
    if (advance) begin
      s1_v    <= sv ? (~value_word + 1'b1) : value_word;
      s1_n    <= sn ? (~numerator_word + 1'b1) : numerator_word;
      s1_d    <= sd ? (~denominator_word + 1'b1) : denominator_word;
      s1_neg  <= sv ^ sn ^ sd;
      s1_zero <= (denominator_word == '0);
    end
  end

  // first division: v / d, carrying n, neg, zero
  logic            d1_vld;
  logic [W-1:0]    d1_q, d1_r, d1_d;
  logic [SIDE-1:0] d1_side;

  pmds_divider #(.W(W), .BITS(BITS_PER_STAGE), .SIDE_W(SIDE)) u_div_a (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(s1_vld), .in_num(s1_v), .in_den(s1_d),
    .in_side({s1_neg, s1_zero, s1_n}),
    .out_valid(d1_vld), .out_quo(d1_q), .out_rem(d1_r), .out_den(d1_d),
    .out_side(d1_side)
  );

  // stage 2: products, wrapped
  logic         s2_vld;
  logic [W-1:0] s2_hi, s2_lo, s2_d;
  logic         s2_neg, s2_zero;
  logic [2*W-1:0] p_hi, p_lo;
  assign p_hi = d1_q * d1_side[W-1:0];
  assign p_lo = d1_r * d1_side[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (advance) begin
      s2_vld <= d1_vld;
    end
    if (advance) begin
      s2_hi   <= p_hi[W-1:0];
      s2_lo   <= p_lo[W-1:0];
      s2_d    <= d1_d;
      s2_neg  <= d1_side[W+1];
      s2_zero <= d1_side[W];
    end
  end

  // second division: (r*n) / d, carrying hi product
  logic            d2_vld;
  logic [W-1:0]    d2_q, d2_r, d2_d;
  logic [SIDE-1:0] d2_side;

  pmds_divider #(.W(W), .BITS(BITS_PER_STAGE), .SIDE_W(SIDE)) u_div_b (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(s2_vld), .in_num(s2_lo), .in_den(s2_d),
    .in_side({s2_neg, s2_zero, s2_hi}),
    .out_valid(d2_vld), .out_quo(d2_q), .out_rem(d2_r), .out_den(d2_d),
    .out_side(d2_side)
  );

  // stage 3: sum
  logic         s3_vld;
  logic [W-1:0] s3_sum;
  logic         s3_neg, s3_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (advance) begin
      s3_vld <= d2_vld;
    end
    if (advance) begin
      s3_sum  <= d2_side[W-1:0] + d2_q;
      s3_neg  <= d2_side[W+1];
      s3_zero <= d2_side[W];
    end
  end

  // output register: sign, zero override
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_vld;
    end
    if (advance) begin
      result_word    <= s3_zero ? '0 : (s3_neg ? (~s3_sum + 1'b1) : s3_sum);
      divide_by_zero <= s3_zero;
    end
  end

  // remainder and carried divisor of the second divider are not needed
  logic unused_ok;
  assign unused_ok = ^{d2_r, d2_d};

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_word == '0)
    else $error("zero denominator gave non-zero result");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_word))
    else $error("result changed while stalled");
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready out of step with output register");
  a_flag_tracks: assert property (@(posedge clk) disable iff (rst)
    advance && s3_vld |=> divide_by_zero == $past(s3_zero))
    else $error("divide_by_zero lost in output stage");
endmodule
